// ===== sv/bgc_pkg.sv =====
// shared types, codes and constants for the button gesture classifier
package bgc_pkg;

  // default timestamp width
  localparam int TIME_BITS_DEF = 48;

  // configuration register width and index codes
  localparam int CFG_W   = 26;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LONG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_GAP    = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] HOLD_LONG_RST  = 26'd5000000;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 26'd800000;
  localparam logic [CFG_W-1:0] TAP_GAP_RST    = 26'd450000;

  // result fields
  localparam int EVENT_W = 3;
  localparam int HELD_W  = 32;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE         = 3'd0,
    EV_HOLD_ACTIVE  = 3'd1,
    EV_HOLD_LONG    = 3'd2,
    EV_LONG_PRESS   = 3'd3,
    EV_DOUBLE_PRESS = 3'd4,
    EV_SHORT_PRESS  = 3'd5
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] hold_long_us;
    logic [CFG_W-1:0] long_press_us;
    logic [CFG_W-1:0] tap_gap_us;
  } cfg_t;

  // microseconds to milliseconds: base-256 long division by 1000
  localparam int DIGIT_BITS = 8;
  localparam int REM_W      = 10;
  localparam int VAL_W      = REM_W + DIGIT_BITS;
  localparam int RECIP_W    = 19;
  localparam int PROD_W     = VAL_W + RECIP_W;
  localparam int RECIP_SHIFT = 28;
  localparam logic [VAL_W-1:0]   MS_DIV = 18'd1000;
  // ceil(2^28 / 1000), exact for every partial dividend below 256000
  localparam logic [RECIP_W-1:0] RECIP_K = 19'd268436;

endpackage

// ===== sv/bgc_classify.sv =====
// gesture state tracking and event decode, first pipeline register
module bgc_classify import bgc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 pressed,
  input  logic [TIME_BITS-1:0] now_us,
  output logic                 s_valid,
  input  logic                 s_stall,
  output event_t               s_event,
  output logic [TIME_BITS-1:0] s_dividend
);

  logic                 was_pressed, was_pressed_next;
  logic [TIME_BITS-1:0] press_start, press_start_next;
  logic [TIME_BITS-1:0] last_release, last_release_next;
  logic [1:0]           tap_count, tap_count_next;
  logic [1:0]           tap_sum;
  logic [TIME_BITS-1:0] el_press, el_rel;
  event_t               ev;
  logic [TIME_BITS-1:0] dividend;
  logic                 accept;

  assign in_stall = s_valid && s_stall;
  assign accept   = in_valid && !in_stall;

  // differences wrap modulo the timestamp width
  assign el_press = now_us - press_start;
  assign el_rel   = now_us - last_release;

  always_comb begin
    was_pressed_next  = was_pressed;
    press_start_next  = press_start;
    last_release_next = last_release;
    tap_count_next    = tap_count;
    tap_sum           = 2'd1;
    ev                = EV_NONE;
    dividend          = '0;
    if (pressed && !was_pressed) begin
      was_pressed_next = 1'b1;
      press_start_next = now_us;
      ev               = EV_HOLD_ACTIVE;
    end else if (pressed) begin
      dividend = el_press;
      ev = (el_press >= {{(TIME_BITS-CFG_W){1'b0}}, cfg.hold_long_us}) ?
           EV_HOLD_LONG : EV_HOLD_ACTIVE;
    end else if (was_pressed) begin
      was_pressed_next = 1'b0;
      press_start_next = '0;
      if (el_press > {{(TIME_BITS-CFG_W){1'b0}}, cfg.long_press_us}) begin
        ev = EV_LONG_PRESS;
      end else begin
        // a tap close after the previous release joins it
        if (el_rel < {{(TIME_BITS-CFG_W){1'b0}}, cfg.tap_gap_us}) begin
          tap_sum = tap_count + 2'd1;
        end
        last_release_next = now_us;
        if (tap_sum[1]) begin
          tap_count_next = 2'd0;
          ev             = EV_DOUBLE_PRESS;
        end else begin
          tap_count_next = tap_sum;
          ev             = EV_SHORT_PRESS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed  <= 1'b0;
      press_start  <= '0;
      last_release <= '0;
      tap_count    <= 2'd0;
      s_valid      <= 1'b0;
    end else begin
      if (accept) begin
        was_pressed  <= was_pressed_next;
        press_start  <= press_start_next;
        last_release <= last_release_next;
        tap_count    <= tap_count_next;
      end
      if (!in_stall) begin
        s_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_event    <= ev;
      s_dividend <= dividend;
    end
  end

endmodule

// ===== sv/bgc_ms_div.sv =====
// pipelined divide by 1000, one base-256 digit per stage
module bgc_ms_div import bgc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  event_t               in_event,
  input  logic [TIME_BITS-1:0] in_dividend,
  output logic                 out_valid,
  input  logic                 out_stall,
  output event_t               out_event,
  output logic [HELD_W-1:0]    out_held_ms
);

  localparam int NCHUNK = (TIME_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PAD_W  = NCHUNK * DIGIT_BITS;

  logic                 v     [NCHUNK];
  event_t               ev    [NCHUNK];
  logic [REM_W-1:0]     rem   [NCHUNK];
  logic [HELD_W-1:0]    quo   [NCHUNK];
  logic [PAD_W-1:0]     dvd   [NCHUNK-1];
  logic                 stall [NCHUNK+1];

  assign stall[NCHUNK] = out_stall;
  assign in_stall      = stall[0];
  assign out_valid     = v[NCHUNK-1];
  assign out_event     = ev[NCHUNK-1];
  assign out_held_ms   = quo[NCHUNK-1];

  for (genvar k = 0; k < NCHUNK; k++) begin : g_stage
    logic                  vin;
    event_t                evin;
    logic [REM_W-1:0]      remin;
    logic [HELD_W-1:0]     quoin;
    logic [PAD_W-1:0]      dvdin;
    logic [VAL_W-1:0]      val;
    logic [PROD_W-1:0]     prod;
    logic [DIGIT_BITS-1:0] digit;
    logic [VAL_W-1:0]      rem_full;

    if (k == 0) begin : g_head
      assign vin   = in_valid;
      assign evin  = in_event;
      assign remin = '0;
      assign quoin = '0;
      assign dvdin = {{(PAD_W-TIME_BITS){1'b0}}, in_dividend};
    end else begin : g_link
      assign vin   = v[k-1];
      assign evin  = ev[k-1];
      assign remin = rem[k-1];
      assign quoin = quo[k-1];
      assign dvdin = dvd[k-1];
    end

    assign stall[k] = v[k] && stall[k+1];

    // partial dividend stays below 1000 * 256
    assign val      = {remin, dvdin[PAD_W-1 -: DIGIT_BITS]};
    assign prod     = PROD_W'(val) * PROD_W'(RECIP_K);
    assign digit    = prod[RECIP_SHIFT +: DIGIT_BITS];
    assign rem_full = val - VAL_W'(digit) * MS_DIV;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (!stall[k]) begin
        v[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (!stall[k] && vin) begin
        ev[k]  <= evin;
        rem[k] <= rem_full[REM_W-1:0];
        quo[k] <= {quoin[HELD_W-DIGIT_BITS-1:0], digit};
      end
    end

    if (k < NCHUNK - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (!stall[k] && vin) begin
          dvd[k] <= {dvdin[PAD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
        end
      end
    end
  end

endmodule

// ===== sv/button_gesture_classifier.sv =====
// top level: configuration registers, gesture decode and held-time pipeline
// an input beat is registered in the decode stage and then in each divide stage on its way to the result beat
// throughput: one beat per cycle unless out_stall holds the pipeline, set by the state update in the decode stage
// the ms conversion is a pipeline of base-256 divide stages, so it never limits rate
// rst (synchronous, active high) clears gesture state, empties the pipeline and
// loads the configuration defaults
module button_gesture_classifier import bgc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 pressed,
  input  logic [TIME_BITS-1:0] now_us,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [EVENT_W-1:0]   event_res,
  output logic [HELD_W-1:0]    held_ms
);

  cfg_t                 cfg;
  logic                 s_valid;
  logic                 s_stall;
  event_t               s_event;
  logic [TIME_BITS-1:0] s_dividend;
  event_t               out_event;

  // configuration registers, an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_long_us  <= HOLD_LONG_RST;
      cfg.long_press_us <= LONG_PRESS_RST;
      cfg.tap_gap_us    <= TAP_GAP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HOLD_LONG:  cfg.hold_long_us  <= cfg_data;
        CFG_LONG_PRESS: cfg.long_press_us <= cfg_data;
        CFG_TAP_GAP:    cfg.tap_gap_us    <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode stage: updates press and tap state on each accepted beat, registers
  // the event and the elapsed press time (zero when released)
  bgc_classify #(
    .TIME_BITS(TIME_BITS)
  ) u_classify (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pressed    (pressed),
    .now_us     (now_us),
    .s_valid    (s_valid),
    .s_stall    (s_stall),
    .s_event    (s_event),
    .s_dividend (s_dividend)
  );

  // elapsed microseconds to milliseconds, low 32 bits kept; the event rides
  // along and the last stage doubles as the output register
  bgc_ms_div #(
    .TIME_BITS(TIME_BITS)
  ) u_ms_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_valid),
    .in_stall    (s_stall),
    .in_event    (s_event),
    .in_dividend (s_dividend),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_event   (out_event),
    .out_held_ms (held_ms)
  );

  assign event_res = out_event;

endmodule

// ===== sv/bgc_checker.sv =====
// port-level checks for the button gesture classifier, bound to the top level
module bgc_checker import bgc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [EVENT_W-1:0] event_res,
  input logic [HELD_W-1:0]  held_ms
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(held_ms))
    else $error("result beat changed while stalled");

  // only hold events carry a held time
  a_held_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_HOLD_ACTIVE && event_res != EV_HOLD_LONG |-> held_ms == '0)
    else $error("held time reported on a released button");

  // back-pressure only comes from a stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat shown right after reset");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the button gesture classifier: directed, random and stall tests
module tb;
  import bgc_pkg::*;

  localparam int TB_TIME_W       = TIME_BITS_DEF;
  localparam int IDLE_PCT        = 26;      // share of idle cycles on either side
  localparam int DRAIN_CYCLES    = 12;      // pipeline is 7 deep at 48 bits, keep a margin
  localparam int HOLD_OFF_CYCLES = 300;     // long receiver hold-off to fill the pipeline
  localparam int CYCLE_LIMIT     = 400000;
  localparam logic [CFG_W-1:0] CFG_MAX = '1;

  // one result beat as the block should present it
  typedef struct packed {
    event_t            ev;
    logic [HELD_W-1:0] ms;
  } gesture_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 pressed;
  logic [TB_TIME_W-1:0] now_us;
  logic                 out_valid;
  logic                 out_stall;
  logic [EVENT_W-1:0]   event_res;
  logic [HELD_W-1:0]    held_ms;

  // results still owed by the block, oldest first
  gesture_result_t pending_results[$];

  // gesture tracker: own copy of the block's state and limits
  logic                 seen_down;
  logic [TB_TIME_W-1:0] press_at;
  logic [TB_TIME_W-1:0] last_tap_at;
  logic [1:0]           tap_run;
  logic [CFG_W-1:0]     lim_hold;
  logic [CFG_W-1:0]     lim_long;
  logic [CFG_W-1:0]     lim_gap;

  logic [TB_TIME_W-1:0] clock_us;       // running timestamp for generated gestures
  int                   beats_sent;
  int                   mismatch_count;
  int                   cycle_count;
  bit                   steady_flow;    // set for stretches with no idling on either side
  bit                   hold_off_req;   // asks the result side for one long hold-off

  button_gesture_classifier DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pressed   (pressed),
    .now_us    (now_us),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res),
    .held_ms   (held_ms)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // runaway guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // work out the result of one accepted sample and advance the tracked state
  task automatic classify_sample(input logic level, input logic [TB_TIME_W-1:0] t);
    gesture_result_t      res;
    logic [TB_TIME_W-1:0] span;
    res.ev = EV_NONE;
    if (level && !seen_down) begin
      // press edge
      press_at  = t;
      seen_down = 1'b1;
      res.ev    = EV_HOLD_ACTIVE;
    end else if (level) begin
      span   = t - press_at;
      res.ev = (span >= lim_hold) ? EV_HOLD_LONG : EV_HOLD_ACTIVE;
    end else if (seen_down) begin
      // release: long press, or a tap that may pair with the last one
      span      = t - press_at;
      seen_down = 1'b0;
      press_at  = '0;
      if (span > lim_long) begin
        res.ev = EV_LONG_PRESS;
      end else begin
        span = t - last_tap_at;
        if (span < lim_gap) tap_run = tap_run + 2'd1;
        else tap_run = 2'd1;
        last_tap_at = t;
        if (tap_run >= 2'd2) begin
          tap_run = 2'd0;
          res.ev  = EV_DOUBLE_PRESS;
        end else begin
          res.ev = EV_SHORT_PRESS;
        end
      end
    end
    span   = t - press_at;
    span   = span / 1000;
    res.ms = level ? span[HELD_W-1:0] : '0;
    pending_results.push_back(res);
  endtask

  // offer one sample beat, with random idle cycles first unless steady_flow is set, and wait for acceptance
  task automatic send_sample(input logic level, input logic [TB_TIME_W-1:0] t);
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    pressed  <= level;
    now_us   <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    classify_sample(level, t);
    beats_sent++;
  endtask

  // stop offering and let every owed result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // limits are only changed with the block drained
  task automatic write_limits(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] lng,
                              input logic [CFG_W-1:0] gap);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_HOLD_LONG;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_data  <= lng;
    @(posedge clk);
    cfg_index <= CFG_TAP_GAP;
    cfg_data  <= gap;
    @(posedge clk);
    cfg_write <= 1'b0;
    lim_hold = hold;
    lim_long = lng;
    lim_gap  = gap;
  endtask

  // a duration or spacing on, just off or well away from a limit
  function automatic logic [TB_TIME_W-1:0] near_limit(input logic [CFG_W-1:0] lim);
    logic [TB_TIME_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = (lim == 0) ? '0 : TB_TIME_W'(lim - 1'b1);
      1: v = TB_TIME_W'(lim);
      2: v = TB_TIME_W'(lim) + 1'b1;
      3: v = TB_TIME_W'($urandom_range(0, lim));
      4: v = TB_TIME_W'(lim) + TB_TIME_W'($urandom_range(1, 1 << 20));
      default: v = TB_TIME_W'($urandom_range(0, 4000));
    endcase
    return v;
  endfunction

  // press length for a tap, mostly within the long-press limit
  function automatic logic [TB_TIME_W-1:0] tap_length();
    logic [TB_TIME_W-1:0] v;
    if ($urandom_range(0, 99) < 80) v = TB_TIME_W'($urandom_range(0, lim_long));
    else v = near_limit(lim_long);
    return v;
  endfunction

  // press, a few held polls, then release after dur
  task automatic press_cycle(input logic [TB_TIME_W-1:0] t_press,
                             input logic [TB_TIME_W-1:0] dur);
    logic [TB_TIME_W-1:0] off;
    int                   polls;
    polls = $urandom_range(0, 3);
    send_sample(1'b1, t_press);
    repeat (polls) begin
      // held polls straddle the hold-long threshold where the press is long enough
      off = near_limit(lim_hold);
      if (off > dur) off = TB_TIME_W'($urandom_range(0, dur[31:0]));
      send_sample(1'b1, t_press + off);
    end
    send_sample(1'b0, t_press + dur);
    clock_us = t_press + dur;
  endtask

  // one random gesture: mostly well-formed, some idle polls and noise
  task automatic run_gesture();
    logic [TB_TIME_W-1:0] spacing;
    logic [TB_TIME_W-1:0] dur;
    int                   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // single tap, release spacing around the gap window
      spacing = near_limit(lim_gap);
      dur     = tap_length();
      if (dur > spacing) dur = spacing;
      press_cycle(clock_us + spacing - dur, dur);
    end else if (pick < 55) begin
      // two taps, second release near the gap window from the first
      press_cycle(clock_us + near_limit(lim_gap), tap_length());
      spacing = near_limit(lim_gap);
      dur     = tap_length();
      if (dur > spacing) dur = spacing;
      press_cycle(clock_us + spacing - dur, dur);
    end else if (pick < 70) begin
      // long hold, around hold-long or long-press limits
      dur = $urandom_range(0, 1) ? near_limit(lim_hold) : near_limit(lim_long);
      press_cycle(clock_us + TB_TIME_W'($urandom_range(0, 1 << 20)), dur);
    end else if (pick < 85) begin
      // released polls
      repeat ($urandom_range(1, 3)) begin
        clock_us = clock_us + TB_TIME_W'($urandom_range(0, 1 << 22));
        send_sample(1'b0, clock_us);
      end
    end else begin
      // noise: random level and timestamp, often close to the wrap point
      if ($urandom_range(0, 1)) clock_us = {16'($urandom), 32'($urandom)};
      else clock_us = '1 - TB_TIME_W'($urandom_range(0, 1 << 21));
      send_sample(1'($urandom_range(0, 1)), clock_us);
    end
  endtask

  task automatic run_items(input int n);
    int target;
    target = beats_sent + n;
    while (beats_sent < target) run_gesture();
  endtask

  // idle at time 0, press recorded at time 0, first tap soon after reset
  task automatic test_reset_defaults();
    send_sample(1'b0, 48'd0);
    send_sample(1'b1, 48'd0);
    send_sample(1'b1, 48'd400);
    send_sample(1'b0, 48'd1000);
  endtask

  // default limits: taps, a double, the long-press and hold-long boundaries
  task automatic test_directed_gestures();
    // press of exactly the long-press limit is still a tap
    send_sample(1'b1, 48'd2000);
    send_sample(1'b0, 48'd802000);
    // next release within the gap window pairs up
    send_sample(1'b1, 48'd900000);
    send_sample(1'b0, 48'd1000000);
    // hold just below and at hold-long, release one past it
    send_sample(1'b1, 48'd2000000);
    send_sample(1'b1, 48'd6999999);
    send_sample(1'b1, 48'd7000000);
    send_sample(1'b0, 48'd7000001);
    // tap, then a long press that leaves the tap count alone
    send_sample(1'b1, 48'd7100000);
    send_sample(1'b0, 48'd7100100);
    send_sample(1'b1, 48'd7200000);
    send_sample(1'b0, 48'd8100000);
    clock_us = 48'd8100000;
  endtask

  // timestamps across the wrap, all ones, and going backwards
  task automatic test_time_wrap();
    send_sample(1'b0, '1);
    send_sample(1'b1, '1 - 49);
    send_sample(1'b1, '1);
    send_sample(1'b0, 48'd30);
    // backwards poll looks like a huge hold, held_ms keeps the low 32 bits
    send_sample(1'b1, 48'd1000000);
    send_sample(1'b1, 48'd999999);
    send_sample(1'b0, 48'd999000);
    clock_us = 48'd999000;
  endtask

  // all limits at zero, then all at full scale
  task automatic test_limit_extremes();
    write_limits('0, '0, '0);
    run_items(60);
    write_limits(CFG_MAX, CFG_MAX, CFG_MAX);
    run_items(60);
  endtask

  // random gestures over several limit settings, one phase without idling
  task automatic test_random_gestures();
    write_limits(HOLD_LONG_RST, LONG_PRESS_RST, TAP_GAP_RST);
    run_items(220);
    write_limits(26'd3000, 26'd2000, 26'd1500);
    run_items(220);
    write_limits(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    steady_flow = 1'b1;
    run_items(220);
    steady_flow = 1'b0;
    write_limits('0, CFG_MAX, CFG_W'($urandom_range(0, 1 << 20)));
    run_items(220);
    write_limits(CFG_W'($urandom_range(0, 1 << 22)), CFG_W'($urandom_range(0, 1 << 21)),
                 CFG_W'($urandom_range(0, 1 << 21)));
    run_items(220);
  endtask

  // result side holds off while samples keep coming, so the input side stalls
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    steady_flow  = 1'b1;
    run_items(100);
    steady_flow  = 1'b0;
    // sender pauses until every result is back
    wait_idle();
    run_items(60);
  endtask

  // result side: check each accepted beat against the oldest expectation, then drive stall
  initial begin : result_sink
    gesture_result_t want;
    int              hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing expected, event_res", event_res, 0);
        end else begin
          want = pending_results.pop_front();
          if (event_res !== want.ev) report_mismatch("event_res", event_res, want.ev);
          if (held_ms !== want.ms) report_mismatch("held_ms", held_ms, want.ms);
        end
      end
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_HOLD_LONG;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    pressed   <= 1'b0;
    now_us    <= '0;
    // tracker starts from the reset state
    seen_down      = 1'b0;
    press_at       = '0;
    last_tap_at    = '0;
    tap_run        = 2'd0;
    lim_hold       = HOLD_LONG_RST;
    lim_long       = LONG_PRESS_RST;
    lim_gap        = TAP_GAP_RST;
    clock_us       = '0;
    beats_sent     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    steady_flow    = 1'b0;
    hold_off_req   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_gestures();
    test_time_wrap();
    test_limit_extremes();
    test_random_gestures();
    test_backpressure();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
